FILE: rtl/b2bcd_pkg.sv
// ----------------------------------------------------------------------------
// b2bcd_pkg
// Shared sizes and constants for the binary to packed BCD converter.
// ----------------------------------------------------------------------------
package b2bcd_pkg;

  localparam int BYTES      = 7;
  localparam int DIGITS     = 2 * BYTES;
  localparam int FIELD_BITS = 8 * BYTES;
  localparam int IN_BITS    = 64;
  localparam int OUT_BITS   = 56;
  localparam int TDATA_BITS = 64;
  localparam int CNT_BITS   = $clog2(IN_BITS);

  function automatic logic [IN_BITS-1:0] largest_value();
    logic [IN_BITS-1:0] p;
    p = 1;
    for (int k = 0; k < DIGITS; k++) begin
      p = p * 10;
    end
    return p - 1;
  endfunction

  localparam logic [IN_BITS-1:0] MAX_VALUE = largest_value();

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_FILL = 3'b100
  } state_t;

endpackage

FILE: rtl/binary_to_packed_bcd_ffill.sv
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_ffill
// Converts a 64-bit unsigned value to a right-aligned packed BCD field with
// 0xF fill in every nibble that holds no significant digit.
//
// The input channel (s_*) carries one binary value per transaction. The
// output channel (m_*) returns one result per input: the BCD field in
// m_tdata[55:0] and the in-range flag in m_tdata[56]. Values above
// 10^(2*BYTES)-1 return all ones in the field and a clear in-range flag.
//
// Conversion is double dabble on one shared add-3-and-shift unit, one input
// bit per cycle: all 64 input bits are shifted through the unit, and then
// the fill step applies the 0xF fill and loads the output register. A new
// value can be taken while the previous result still waits in that register.
// s_tready is high only while the converter is idle.
//
// Reset clears the sequencer and the output valid. When the receiver stalls,
// the result holds in the output register; a finished conversion waits in
// its fill step until that register is free, and s_tready stays low.
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_ffill (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [55:0] packed_bcd, [56] in_range, [63:57] zero
);

  localparam int DBITS = 4 * b2bcd_pkg::DIGITS;

  b2bcd_pkg::state_t state;
  logic [b2bcd_pkg::IN_BITS-1:0]  shreg;
  logic [DBITS-1:0]               bcd;
  logic [DBITS-1:0]               bcd_next;
  logic [b2bcd_pkg::CNT_BITS-1:0] cnt;
  logic                           in_range;
  logic [b2bcd_pkg::OUT_BITS-1:0] field_next;
  logic                           out_free;

  assign s_tready = (state == b2bcd_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    logic [DBITS-1:0] adj;
    adj = bcd;
    for (int i = 0; i < b2bcd_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[DBITS-2:0], shreg[b2bcd_pkg::IN_BITS-1]};
  end

  always_comb begin
    logic seen;
    logic [DBITS-1:0] filled;
    seen   = 1'b0;
    filled = bcd;
    for (int i = b2bcd_pkg::DIGITS - 1; i >= 0; i--) begin
      seen = seen || (bcd[4*i +: 4] != 4'd0);
      if (!seen) begin
        filled[4*i +: 4] = 4'hF;
      end
    end
    field_next = '0;
    if (in_range) begin
      field_next[b2bcd_pkg::FIELD_BITS-1:0] = filled;
    end else begin
      field_next[b2bcd_pkg::FIELD_BITS-1:0] = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= b2bcd_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (state == b2bcd_pkg::ST_FILL && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        b2bcd_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            state <= b2bcd_pkg::ST_CONV;
            cnt   <= '0;
          end
        end
        b2bcd_pkg::ST_CONV: begin
          cnt <= cnt + 1'b1;
          if (cnt == {b2bcd_pkg::CNT_BITS{1'b1}}) begin
            state <= b2bcd_pkg::ST_FILL;
          end
        end
        b2bcd_pkg::ST_FILL: begin
          if (out_free) begin
            state <= b2bcd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= b2bcd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      b2bcd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          shreg    <= s_tdata;
          bcd      <= '0;
          in_range <= (s_tdata <= b2bcd_pkg::MAX_VALUE);
        end
      end
      b2bcd_pkg::ST_CONV: begin
        bcd   <= bcd_next;
        shreg <= {shreg[b2bcd_pkg::IN_BITS-2:0], 1'b0};
      end
      b2bcd_pkg::ST_FILL: begin
        if (out_free) begin
          m_tdata <= {{(b2bcd_pkg::TDATA_BITS - b2bcd_pkg::OUT_BITS - 1){1'b0}},
                      in_range, field_next};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
